// ===== rtl/bphc_pkg.sv =====
// ----------------------------------------------------------------------------
// bphc_pkg
// Shared types and constants for the button press-and-hold classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bphc_pkg;

  // default width of the millisecond time base
  localparam int TIME_BITS_DEFAULT = 32;

  // configuration register geometry
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE       = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_LOCKOUT   = 2'd2;

  // configuration reset values
  localparam logic [CFG_BITS-1:0] HOLD_THRESHOLD_RESET = 16'd1500;
  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET       = 16'd200;
  localparam logic [CFG_BITS-1:0] HOLD_LOCKOUT_RESET   = 16'd2000;

  // event codes
  localparam int EV_BITS = 2;
  localparam logic [EV_BITS-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_BITS-1:0] EV_PRESS = 2'd1;
  localparam logic [EV_BITS-1:0] EV_HOLD  = 2'd2;

  // live configuration handed to the classifier
  typedef struct packed {
    logic [CFG_BITS-1:0] hold_threshold_ms;
    logic [CFG_BITS-1:0] debounce_ms;
    logic [CFG_BITS-1:0] hold_lockout_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/bphc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bphc_cfg_regs
// Configuration register file: threshold, debounce gap and hold lockout.
// ----------------------------------------------------------------------------
`default_nettype none

module bphc_cfg_regs
  import bphc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  output cfg_t                         cfg
);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_threshold_ms <= HOLD_THRESHOLD_RESET;
      cfg.debounce_ms       <= DEBOUNCE_RESET;
      cfg.hold_lockout_ms   <= HOLD_LOCKOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOLD_THRESHOLD: cfg.hold_threshold_ms <= cfg_data;
        CFG_DEBOUNCE:       cfg.debounce_ms       <= cfg_data;
        CFG_HOLD_LOCKOUT:   cfg.hold_lockout_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bphc_classify.sv =====
// ----------------------------------------------------------------------------
// bphc_classify
// Press/hold state and the combinational classification of one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bphc_classify
  import bphc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire cfg_t                 cfg,
  input  wire logic                 down,
  input  wire logic [TIME_BITS-1:0] now,
  output logic      [EV_BITS-1:0]   event_code
);

  // state
  logic [TIME_BITS-1:0] hold_start_time, hold_start_time_next;
  logic [TIME_BITS-1:0] last_press_time, last_press_time_next;
  logic [TIME_BITS-1:0] last_hold_time, last_hold_time_next;
  logic                 press_pending, press_pending_next;
  logic                 suppress_next, suppress_next_next;

  // elapsed times, wrapping
  logic [TIME_BITS-1:0] held_for;
  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] since_hold;
  logic                 hold_met;
  logic                 gap_met;
  logic                 lockout_met;

  always_comb begin
    held_for    = now - hold_start_time;
    since_press = now - last_press_time;
    since_hold  = now - last_hold_time;
    hold_met    = held_for    >= TIME_BITS'(cfg.hold_threshold_ms);
    gap_met     = since_press >= TIME_BITS'(cfg.debounce_ms);
    lockout_met = since_hold  >= TIME_BITS'(cfg.hold_lockout_ms);
  end

  // classification and next state
  always_comb begin
    hold_start_time_next = hold_start_time;
    last_press_time_next = last_press_time;
    last_hold_time_next  = last_hold_time;
    press_pending_next   = press_pending;
    suppress_next_next   = suppress_next;
    event_code           = EV_NONE;
    priority if (!down) begin
      // release ends any hold and reports a pending short press
      hold_start_time_next = '0;
      last_hold_time_next  = '0;
      suppress_next_next   = 1'b0;
      press_pending_next   = 1'b0;
      if (press_pending) begin
        event_code = EV_PRESS;
      end
    end else if (hold_start_time != '0) begin
      // held long enough: report hold once and lock out
      if (hold_met) begin
        hold_start_time_next = '0;
        last_press_time_next = now;
        last_hold_time_next  = now;
        press_pending_next   = 1'b0;
        suppress_next_next   = 1'b1;
        event_code           = EV_HOLD;
      end
    end else if (gap_met && lockout_met && !suppress_next) begin
      // new press accepted
      last_press_time_next = now;
      hold_start_time_next = now;
      press_pending_next   = 1'b1;
    end else begin
      // press gated by debounce, lockout or suppression: state holds
    end
  end

  // state update when an item passes through
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_start_time <= '0;
      last_press_time <= '0;
      last_hold_time  <= '0;
      press_pending   <= 1'b0;
      suppress_next   <= 1'b0;
    end else if (step) begin
      hold_start_time <= hold_start_time_next;
      last_press_time <= last_press_time_next;
      last_hold_time  <= last_hold_time_next;
      press_pending   <= press_pending_next;
      suppress_next   <= suppress_next_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/button_press_and_hold_classifier_core.sv =====
// ----------------------------------------------------------------------------
// button_press_and_hold_classifier_core
// Classifies timestamped button samples into short press and press-and-hold.
// ----------------------------------------------------------------------------
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------
//   input    | in_valid / in_stall | button_down, now_ms
//   output   | out_valid/out_stall | button_event
//   config   | cfg_we              | cfg_index, cfg_data
//
// One item per cycle sustained while the result port does not stall; out_valid
// rises once the item has passed the input register, then the result register.
// The classification and state update happen combinationally between
// the input register and the result register.
// Reset restores the register defaults and clears all press/hold state.
// A stalled result holds the result register; in_stall rises only when
// the input register is full and the result register is full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_and_hold_classifier_core
  import bphc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    button_down,
  input  wire logic [31:0]             now_ms,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [EV_BITS-1:0]      button_event,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data
);

  cfg_t                 cfg;
  logic                 in_full;
  logic                 in_down;
  logic [TIME_BITS-1:0] in_now;
  logic                 in_take;
  logic                 advance;
  logic [EV_BITS-1:0]   event_code;

  // handshake
  assign advance   = in_full && !(out_valid && out_stall);
  assign in_stall  = in_full && out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;

  bphc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_down <= button_down;
      in_now  <= TIME_BITS'(now_ms);
    end
  end

  bphc_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .cfg        (cfg),
    .down       (in_down),
    .now        (in_now),
    .event_code (event_code)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      button_event <= event_code;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bphc_checker.sv =====
// ----------------------------------------------------------------------------
// bphc_checker
// Port-level checks for the button press-and-hold classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module bphc_checker
  import bphc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [EV_BITS-1:0] button_event
);

  // only defined event codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (button_event == EV_NONE || button_event == EV_PRESS ||
                   button_event == EV_HOLD))
    else $error("undefined event code");

  // input side stalls only behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with free result register");

  // nothing comes out right after reset
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(button_event)))
    else $error("stalled result changed");

endmodule

bind button_press_and_hold_classifier_core bphc_checker u_bphc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .button_event (button_event)
);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for button_press_and_hold_classifier_core: timestamped button
// samples go in under random bursts and gaps, the result port stalls on
// its own pattern, and every event is checked against an in-bench model.
// ----------------------------------------------------------------------------

module tb;
  import bphc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 80;
  localparam int PHASE_ITEMS    = 100;
  localparam int MAX_REPORTS    = 20;

  // index past the last register, writes to it are dropped
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct {
    logic        down;
    logic [31:0] stamp;
  } sample_t;

  logic                    clk         = 1'b0;
  logic                    rst         = 1'b1;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic                    button_down = 1'b0;
  logic [31:0]             now_ms      = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic [EV_BITS-1:0]      button_event;
  logic                    cfg_we      = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index   = '0;
  logic [CFG_BITS-1:0]     cfg_data    = '0;

  button_press_and_hold_classifier_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .button_down  (button_down),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .button_event (button_event),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // pending samples and the events they should produce
  sample_t            pending_samples[$];
  logic [EV_BITS-1:0] expected_events[$];

  // model copy of the registers and the press/hold state
  cfg_t        model_cfg;
  logic [31:0] held_since;
  logic [31:0] last_press_ms;
  logic [31:0] last_hold_ms;
  logic        press_open;
  logic        hold_latch;

  int          errors      = 0;
  int          items_in    = 0;
  int          results_out = 0;
  int          short_count = 0;
  int          hold_count  = 0;
  int          queued      = 0;
  logic [31:0] sim_ms      = '0;

  // classify one sample and update the model state
  function automatic logic [EV_BITS-1:0] classify_sample(input logic down,
                                                         input logic [31:0] stamp);
    logic [31:0] since_hold_start;
    logic [31:0] since_press;
    logic [31:0] since_hold;
    since_hold_start = stamp - held_since;
    since_press      = stamp - last_press_ms;
    since_hold       = stamp - last_hold_ms;
    if (!down) begin
      held_since   = '0;
      last_hold_ms = '0;
      hold_latch   = 1'b0;
      if (press_open) begin
        press_open = 1'b0;
        return EV_PRESS;
      end
      return EV_NONE;
    end
    if (held_since != '0) begin
      if (since_hold_start >= {16'd0, model_cfg.hold_threshold_ms}) begin
        held_since    = '0;
        last_press_ms = stamp;
        last_hold_ms  = stamp;
        press_open    = 1'b0;
        hold_latch    = 1'b1;
        return EV_HOLD;
      end
      return EV_NONE;
    end
    if (since_press >= {16'd0, model_cfg.debounce_ms} &&
        since_hold >= {16'd0, model_cfg.hold_lockout_ms} && !hold_latch) begin
      last_press_ms = stamp;
      held_since    = stamp;
      press_open    = 1'b1;
    end
    return EV_NONE;
  endfunction

  // driver: bursts of items with random gaps between them
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : drive_proc
    sample_t            s;
    logic [EV_BITS-1:0] ev;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        ev = classify_sample(button_down, now_ms);
        expected_events.push_back(ev);
        items_in++;
        if (ev == EV_PRESS) short_count++;
        if (ev == EV_HOLD) hold_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          s = pending_samples.pop_front();
          in_valid    <= 1'b1;
          button_down <= s.down;
          now_ms      <= s.stamp;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall pattern, with long hold-offs to back the block up
  int mode;
  int mode_left;
  int long_left;
  int seen_in;
  int next_long;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      mode      <= 0;
      mode_left <= 0;
      long_left <= 0;
      seen_in   <= 0;
      next_long <= 350;
    end else begin
      if (in_valid && !in_stall) seen_in <= seen_in + 1;
      if (long_left != 0) begin
        out_stall <= 1'b1;
        long_left <= long_left - 1;
      end else if (seen_in >= next_long) begin
        out_stall <= 1'b1;
        long_left <= LONG_HOLD;
        next_long <= next_long + 750;
      end else begin
        if (mode_left == 0) begin
          mode      <= $urandom_range(0, 3);
          mode_left <= $urandom_range(20, 200);
        end else begin
          mode_left <= mode_left - 1;
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 7) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // monitor: compare each event with the oldest expectation
  always @(posedge clk) begin : check_proc
    logic [EV_BITS-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      results_out++;
      if (expected_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected event, expected none, actual %0d", $time, button_event);
      end else begin
        want = expected_events.pop_front();
        if (button_event !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: button_event mismatch, expected %0d, actual %0d",
                     $time, want, button_event);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  int quiet;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic add_item(input logic down, input logic [31:0] stamp);
    sample_t s;
    s.down  = down;
    s.stamp = stamp;
    pending_samples.push_back(s);
    queued++;
  endtask

  // one press: a few released samples, then a run of down samples
  task automatic add_press(input int unsigned step);
    int n_up;
    int n_down;
    n_up   = $urandom_range(1, 3);
    n_down = $urandom_range(1, 10);
    repeat (n_up) begin
      sim_ms += ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4 * step) : $urandom_range(0, step);
      add_item(1'b0, sim_ms);
    end
    repeat (n_down) begin
      sim_ms += $urandom_range(0, step);
      add_item(1'b1, sim_ms);
    end
  endtask

  // random samples, time running backwards, or a jump anywhere
  task automatic add_noise(input int unsigned step);
    int pick;
    pick = $urandom_range(0, 2);
    case (pick)
      0: add_item(1'($urandom_range(0, 1)), $urandom());
      1: add_item(1'($urandom_range(0, 1)), sim_ms - $urandom_range(0, step));
      default: begin
        sim_ms = $urandom();
        add_item(1'b1, sim_ms);
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_HOLD_THRESHOLD: model_cfg.hold_threshold_ms = val;
      CFG_DEBOUNCE:       model_cfg.debounce_ms       = val;
      CFG_HOLD_LOCKOUT:   model_cfg.hold_lockout_ms   = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [CFG_BITS-1:0] thr, input logic [CFG_BITS-1:0] deb,
                           input logic [CFG_BITS-1:0] lockout_val);
    write_reg(CFG_HOLD_THRESHOLD, thr);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_HOLD_LOCKOUT, lockout_val);
  endtask

  // wait until all items are sent and all events are back
  task automatic wait_idle();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stim_proc
    int          ph;
    int          target;
    int unsigned step;
    logic [CFG_BITS-1:0] thr;
    logic [CFG_BITS-1:0] deb;
    logic [CFG_BITS-1:0] lockout_val;

    model_cfg.hold_threshold_ms = HOLD_THRESHOLD_RESET;
    model_cfg.debounce_ms       = DEBOUNCE_RESET;
    model_cfg.hold_lockout_ms   = HOLD_LOCKOUT_RESET;
    held_since    = '0;
    last_press_ms = '0;
    last_hold_ms  = '0;
    press_open    = 1'b0;
    hold_latch    = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: debounce at time zero, hold, suppression, short press
    add_item(1'b1, 32'd0);
    add_item(1'b1, 32'd2000);
    add_item(1'b1, 32'd3499);
    add_item(1'b1, 32'd3500);
    add_item(1'b1, 32'd3600);
    add_item(1'b0, 32'd3650);
    add_item(1'b1, 32'd3700);
    add_item(1'b0, 32'd3800);
    add_item(1'b1, 32'd3850);
    add_item(1'b0, 32'd3900);
    // hold that spans the time wrap
    add_item(1'b1, 32'hFFFF_FF00);
    add_item(1'b1, 32'h0000_04DB);
    add_item(1'b1, 32'h0000_04DC);
    add_item(1'b0, 32'h0000_0500);
    wait_idle();

    // zero registers, press taken at time zero reads as not held
    write_all('0, '0, '0);
    end_writes();
    add_item(1'b1, 32'd0);
    add_item(1'b0, 32'd1);
    add_item(1'b1, 32'd0);
    add_item(1'b1, 32'd0);
    add_item(1'b1, 32'd5);
    add_item(1'b1, 32'd6);
    add_item(1'b1, 32'd7);
    add_item(1'b0, 32'd8);
    wait_idle();

    // out-of-range index is dropped, then all registers at their maximum
    write_reg(CFG_UNUSED_IDX, 16'h5A5A);
    write_all('1, '1, '1);
    end_writes();
    add_item(1'b1, 32'h8000_0000);
    add_item(1'b1, 32'h8000_0000 + 32'd65534);
    add_item(1'b1, 32'h8000_0000 + 32'd65535);
    add_item(1'b0, 32'h8000_0000 + 32'd65600);
    add_item(1'b1, 32'h8000_0000 + 32'd65635);
    wait_idle();

    // random phases over a rotation of register settings
    sim_ms = 32'd100000;
    for (ph = 0; ph < 14; ph++) begin
      case (ph % 7)
        0: begin
          thr = HOLD_THRESHOLD_RESET; deb = DEBOUNCE_RESET; lockout_val = HOLD_LOCKOUT_RESET;
          step = 400;
        end
        1: begin
          thr = CFG_BITS'($urandom_range(1, 20)); deb = CFG_BITS'($urandom_range(0, 5));
          lockout_val = CFG_BITS'($urandom_range(0, 10));
          step = 8;
        end
        2: begin
          thr = '0; deb = '0; lockout_val = '0;
          step = 3;
        end
        3: begin
          thr = '1; deb = '1; lockout_val = '1;
          step = 20000;
        end
        4: begin
          thr = CFG_BITS'($urandom()); deb = CFG_BITS'($urandom());
          lockout_val = CFG_BITS'($urandom());
          step = (thr >> 2) + 1;
        end
        5: begin
          thr = CFG_BITS'($urandom_range(1, 20)); deb = CFG_BITS'($urandom_range(0, 5));
          lockout_val = CFG_BITS'($urandom_range(0, 10));
          step = 8;
          sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        end
        default: begin
          thr = CFG_BITS'($urandom_range(0, 3)); deb = CFG_BITS'($urandom_range(0, 3));
          lockout_val = CFG_BITS'($urandom_range(0, 6));
          step = 4;
        end
      endcase
      wait_idle();
      if (ph % 7 == 6) write_reg(CFG_UNUSED_IDX, CFG_BITS'($urandom()));
      write_all(thr, deb, lockout_val);
      end_writes();
      target = queued + PHASE_ITEMS;
      while (queued < target) begin
        if ($urandom_range(0, 99) < 15) add_noise(step);
        else add_press(step);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (expected_events.size() != 0) begin
      errors++;
      $display("%0t: %0d events never arrived", $time, expected_events.size());
    end

    $display("run covered %0d samples and %0d events over 17 register settings",
             items_in, results_out);
    $display("events seen: %0d short presses, %0d press-and-holds", short_count, hold_count);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
